[sv/wpl_pkg.sv]
// Shared types, constants and codes of the windowed probe lookup cache.
package wpl_pkg;

  localparam int INITIAL_SLOTS_DEF = 1024;
  localparam int MAX_SLOTS_DEF     = 4096;
  localparam int WIN_SLOTS_DEF     = 8;
  localparam int ROOT_SHIFT        = 4;

  localparam int ROOT_W    = 48;
  localparam int WORD_W    = 64;
  localparam int IN_DATA_W = 240;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_INS  = 2'd3
  } ins_status_t;

  // Which bound ends a sweep over the slot index.
  typedef enum logic [1:0] {
    LIM_ALL,
    LIM_SIZE,
    LIM_HALF
  } lim_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PRB_RD,
    S_PRB_CMP,
    S_COPY_RD,
    S_COPY_WR,
    S_MIG_RD,
    S_MIG_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] root;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] hash;
    logic [WORD_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic        load_in;
    logic        load_scr;
    logic        probe_start;
    logic        probe_next;
    logic        slot_rd_probe;
    logic        slot_wr_entry;
    logic        slot_rd_sweep;
    logic        slot_wr_zero;
    logic        scr_rd_sweep;
    logic        scr_wr_sweep;
    logic        sweep_rst;
    logic        sweep_inc;
    lim_t        lim;
    logic        cnt_clr;
    logic        cnt_inc;
    logic        size_dbl;
    logic        set_hit;
    logic        set_stat;
    ins_status_t stat;
    logic        set_grew;
    logic        out_load;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic slot_empty;
    logic slot_match;
    logic probe_last;
    logic sweep_last;
    logic grow_need;
    logic scr_valid;
    logic out_free;
  } ctl_sts_t;

endpackage

[sv/windowed_probe_lookup_cache.sv]
// Top level of the windowed probe lookup cache.
//
// One input transaction carries a command (in_tuser) and a key with its hash,
// root and fill value (in_tdata); every command gives exactly one result
// transaction on the out_ channel. A lookup or insert reads the window slots
// one after another from the single-port slot memory, a read state and then
// a compare state for each slot, and then delivers its result.
// A clear command sweeps all MAX_SLOTS slots of the slot memory. An insert
// that doubles the table first copies the old table to scratch memory,
// zeroing the old slots, then re-inserts every occupied old slot into the
// doubled table. After reset the block clears the whole slot memory with
// in_tready low; the table size returns to INITIAL_SLOTS.
// Results sit in an output register; the next transaction is taken while a
// result waits, and a finished command holds until out_tready frees the
// register.
module windowed_probe_lookup_cache import wpl_pkg::*; #(
  parameter int INITIAL_SLOTS = INITIAL_SLOTS_DEF,
  parameter int MAX_SLOTS     = MAX_SLOTS_DEF,
  parameter int WIN_SLOTS     = WIN_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // root_handle[47:0], key_id[111:48], key_hash[175:112], fill_value[239:176]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // hit[0], hit_value[64:1], insert_status[66:65], grew[67], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  wpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wpl_datapath #(
    .INITIAL_SLOTS (INITIAL_SLOTS),
    .MAX_SLOTS     (MAX_SLOTS),
    .WIN_SLOTS     (WIN_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[sv/wpl_ctrl.sv]
// Controller state machine of the windowed probe lookup cache.
module wpl_ctrl import wpl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   mig_r, mig_nxt;
  logic   clr_r, clr_nxt;
  logic   prb_end;

  // A probe ends at an empty slot, at a matching entry or after the window.
  assign prb_end = sts.slot_empty || sts.slot_match || sts.probe_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      op_r    <= OP_NONE;
      mig_r   <= 1'b0;
      clr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      mig_r   <= mig_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    mig_nxt   = mig_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLR: begin
        if (sts.sweep_last) begin
          state_nxt = clr_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = sts.in_op;
          unique case (sts.in_op)
            OP_LOOKUP, OP_INSERT: state_nxt = S_PRB_RD;
            OP_CLEAR: begin
              state_nxt = S_CLR;
              clr_nxt   = 1'b1;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PRB_RD: state_nxt = S_PRB_CMP;
      S_PRB_CMP: begin
        if (mig_r) begin
          if (prb_end) begin
            if (sts.sweep_last) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_MIG_RD;
            end
          end else begin
            state_nxt = S_PRB_RD;
          end
        end else if (op_r == OP_INSERT && sts.slot_empty && sts.grow_need) begin
          state_nxt = S_COPY_RD;
        end else if (prb_end) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PRB_RD;
        end
      end
      S_COPY_RD: state_nxt = S_COPY_WR;
      S_COPY_WR: begin
        if (sts.sweep_last) begin
          state_nxt = S_MIG_RD;
          mig_nxt   = 1'b1;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end
      S_MIG_RD: state_nxt = S_MIG_CHK;
      S_MIG_CHK: begin
        if (sts.scr_valid) begin
          state_nxt = S_PRB_RD;
        end else if (sts.sweep_last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MIG_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
          mig_nxt   = 1'b0;
          clr_nxt   = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.lim   = LIM_HALF;
    cmd.stat  = ST_NOT_INS;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.lim          = LIM_ALL;
        cmd.slot_wr_zero = 1'b1;
        cmd.sweep_inc    = 1'b1;
        cmd.cnt_clr      = 1'b1;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in     = 1'b1;
          cmd.probe_start = 1'b1;
          cmd.sweep_rst   = 1'b1;
        end
      end
      S_PRB_RD: cmd.slot_rd_probe = 1'b1;
      S_PRB_CMP: begin
        cmd.probe_next = 1'b1;
        if (mig_r) begin
          if (sts.slot_empty) begin
            cmd.slot_wr_entry = 1'b1;
            cmd.cnt_inc       = 1'b1;
          end
          if (prb_end) begin
            cmd.sweep_inc = 1'b1;
          end
        end else if (op_r == OP_LOOKUP) begin
          cmd.set_hit = !sts.slot_empty && sts.slot_match;
        end else if (sts.slot_empty) begin
          cmd.slot_wr_entry = 1'b1;
          cmd.cnt_inc       = 1'b1;
          cmd.set_stat      = 1'b1;
          cmd.stat          = ST_INSERTED;
          if (sts.grow_need) begin
            cmd.set_grew  = 1'b1;
            cmd.sweep_rst = 1'b1;
          end
        end else if (sts.slot_match) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = ST_DUP;
        end else if (sts.probe_last) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = ST_FULL;
        end
      end
      S_COPY_RD: begin
        cmd.lim           = LIM_SIZE;
        cmd.slot_rd_sweep = 1'b1;
      end
      S_COPY_WR: begin
        cmd.lim          = LIM_SIZE;
        cmd.scr_wr_sweep = 1'b1;
        cmd.slot_wr_zero = 1'b1;
        if (sts.sweep_last) begin
          cmd.size_dbl  = 1'b1;
          cmd.cnt_clr   = 1'b1;
          cmd.sweep_rst = 1'b1;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_MIG_RD: cmd.scr_rd_sweep = 1'b1;
      S_MIG_CHK: begin
        if (sts.scr_valid) begin
          cmd.load_scr    = 1'b1;
          cmd.probe_start = 1'b1;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[sv/wpl_datapath.sv]
// Datapath of the windowed probe lookup cache: slot and scratch memories, probe and sweep.
module wpl_datapath import wpl_pkg::*; #(
  parameter int INITIAL_SLOTS = INITIAL_SLOTS_DEF,
  parameter int MAX_SLOTS     = MAX_SLOTS_DEF,
  parameter int WIN_SLOTS     = WIN_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts
);

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int SZ_W   = IDX_W + 1;
  localparam int STEP_W = $clog2(WIN_SLOTS + 1);

  slot_t slot_mem [MAX_SLOTS];
  slot_t scr_mem  [MAX_SLOTS];
  slot_t slot_q, scr_q;

  slot_t             ent_r, ent_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SZ_W-1:0]   sweep_r, sweep_nxt;
  logic [SZ_W-1:0]   size_r, size_nxt;
  logic [SZ_W-1:0]   cnt_r, cnt_nxt;
  logic [SZ_W-1:0]   lim;
  logic [SZ_W:0]     cnt2;
  logic [IDX_W-1:0]  mask;
  logic [IDX_W-1:0]  base;
  logic [IDX_W-1:0]  sweep_idx;
  slot_t             in_ent;
  slot_t             src;

  logic              res_hit_r;
  logic [WORD_W-1:0] res_val_r;
  ins_status_t       res_stat_r;
  logic              res_grew_r;
  logic              out_valid_r;
  logic              out_hit_r, out_grew_r;
  logic [WORD_W-1:0] out_val_r;
  ins_status_t       out_stat_r;

  logic              slot_we, slot_re;
  logic [IDX_W-1:0]  slot_waddr, slot_raddr;
  slot_t             slot_wdata;

  assign in_ent.valid = 1'b1;
  assign in_ent.root  = in_tdata[ROOT_W-1:0];
  assign in_ent.key   = in_tdata[ROOT_W+WORD_W-1:ROOT_W];
  assign in_ent.hash  = in_tdata[ROOT_W+2*WORD_W-1:ROOT_W+WORD_W];
  assign in_ent.value = in_tdata[ROOT_W+3*WORD_W-1:ROOT_W+2*WORD_W];

  assign src       = cmd.load_in ? in_ent : scr_q;
  assign mask      = IDX_W'(size_r - 1'b1);
  assign base      = (src.hash[IDX_W-1:0] ^ IDX_W'(src.root >> ROOT_SHIFT)) & mask;
  assign sweep_idx = sweep_r[IDX_W-1:0];

  always_comb begin
    case (cmd.lim)
      LIM_ALL:  lim = SZ_W'(MAX_SLOTS);
      LIM_SIZE: lim = size_r;
      default:  lim = size_r >> 1;
    endcase
  end

  // Twice the count after this insert, against the current size.
  assign cnt2 = ({1'b0, cnt_r} + 1'b1) << 1;

  assign sts.in_op      = op_t'(in_tuser);
  assign sts.slot_empty = !slot_q.valid;
  assign sts.slot_match = (slot_q.root == ent_r.root) && (slot_q.key == ent_r.key);
  assign sts.probe_last = (step_r == STEP_W'(WIN_SLOTS - 1));
  assign sts.sweep_last = ((sweep_r + 1'b1) == lim);
  assign sts.grow_need  = (cnt2 >= {1'b0, size_r}) && (size_r < SZ_W'(MAX_SLOTS));
  assign sts.scr_valid  = scr_q.valid;
  assign sts.out_free   = !out_valid_r || out_tready;

  always_comb begin
    ent_nxt   = ent_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    sweep_nxt = sweep_r;
    size_nxt  = size_r;
    cnt_nxt   = cnt_r;
    if (cmd.load_in || cmd.load_scr) begin
      ent_nxt = src;
    end
    if (cmd.probe_start) begin
      idx_nxt  = base;
      step_nxt = '0;
    end else if (cmd.probe_next) begin
      idx_nxt  = (idx_r + 1'b1) & mask;
      step_nxt = step_r + 1'b1;
    end
    if (cmd.sweep_rst) begin
      sweep_nxt = '0;
    end else if (cmd.sweep_inc) begin
      sweep_nxt = sts.sweep_last ? '0 : sweep_r + 1'b1;
    end
    if (cmd.size_dbl) begin
      size_nxt = size_r << 1;
    end
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      size_r      <= SZ_W'(INITIAL_SLOTS);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sweep_r <= sweep_nxt;
      size_r  <= size_nxt;
      cnt_r   <= cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    idx_r  <= idx_nxt;
    step_r <= step_nxt;
    if (cmd.load_in) begin
      res_hit_r  <= 1'b0;
      res_val_r  <= '0;
      res_stat_r <= ST_NOT_INS;
      res_grew_r <= 1'b0;
    end else begin
      if (cmd.set_hit) begin
        res_hit_r <= 1'b1;
        res_val_r <= slot_q.value;
      end
      if (cmd.set_stat) begin
        res_stat_r <= cmd.stat;
      end
      if (cmd.set_grew) begin
        res_grew_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_hit_r  <= res_hit_r;
      out_val_r  <= res_val_r;
      out_stat_r <= res_stat_r;
      out_grew_r <= res_grew_r;
    end
  end

  assign slot_we    = cmd.slot_wr_entry || cmd.slot_wr_zero;
  assign slot_waddr = cmd.slot_wr_entry ? idx_r : sweep_idx;
  assign slot_wdata = cmd.slot_wr_entry ? ent_r : slot_t'('0);
  assign slot_re    = cmd.slot_rd_probe || cmd.slot_rd_sweep;
  assign slot_raddr = cmd.slot_rd_probe ? idx_r : sweep_idx;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_q <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scr_wr_sweep) begin
      scr_mem[sweep_idx] <= slot_q;
    end
    if (cmd.scr_rd_sweep) begin
      scr_q <= scr_mem[sweep_idx];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_grew_r, out_stat_r, out_val_r, out_hit_r};

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SZ_W'(MAX_SLOTS))
    else $error("table size beyond the slot memory");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= size_r)
    else $error("entry count exceeds table size");

  a_wr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_wr_entry |-> !slot_q.valid)
    else $error("entry written over an occupied slot");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending transaction");

endmodule
